FILE: src/ftbp_pkg.sv
package ftbp_pkg;

   localparam int FIELD_COUNT     = 47;
   localparam int BIT_LIMIT       = 758;
   localparam int ENTITY_NUM_BITS = 10;
   localparam int ANIM_FIELD_BITS = 10;

   localparam int ADDR_W = $clog2(FIELD_COUNT);
   localparam int CUR_W  = $clog2(FIELD_COUNT + 1);
   localparam int WORD_W = 32;
   localparam int CNT_W  = 6;
   localparam int POS_W  = 10;
   localparam int WID_W  = 6;
   localparam int TAB_N  = 64;

   // opcodes
   localparam logic [3:0] OP_START_WRITE  = 4'd0;
   localparam logic [3:0] OP_START_READ   = 4'd1;
   localparam logic [3:0] OP_WRITE        = 4'd2;
   localparam logic [3:0] OP_WRITE_SIGNED = 4'd3;
   localparam logic [3:0] OP_READ         = 4'd4;
   localparam logic [3:0] OP_READ_SIGNED  = 4'd5;
   localparam logic [3:0] OP_SKIP         = 4'd6;
   localparam logic [3:0] OP_LOAD_FIELD   = 4'd7;
   localparam logic [3:0] OP_FETCH_FIELD  = 4'd8;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_LIMIT = 2'd1;
   localparam logic [1:0] ST_MODE  = 2'd2;
   localparam logic [1:0] ST_INDEX = 2'd3;

   localparam logic [WID_W-1:0] EW = WID_W'(ENTITY_NUM_BITS);
   localparam logic [WID_W-1:0] AW = WID_W'(ANIM_FIELD_BITS);

   // stream width of each field word; the last word has no stream width
   localparam logic [WID_W-1:0] WIDTH_TABLE [TAB_N] = '{
      6'd24, 6'd8,  6'd32, 6'd32,
      6'd8,  6'd32, 6'd32,
      6'd32, 6'd32,
      EW,    EW,    EW,
      6'd8,  6'd32, 6'd32,
      6'd9,  6'd9,  6'd16, 6'd8, 6'd24, 6'd10, 6'd8, 6'd8,
      6'd8,  6'd8,  6'd8,  6'd8,
      6'd8,  6'd8,  6'd8,  6'd8,
      6'd16, 6'd8,
      AW,    AW,
      6'd10, 6'd32, 6'd32, 6'd32,
      6'd8,  6'd8,
      6'd32, 6'd32, 6'd32,
      6'd4,  6'd2,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0
   };

   function automatic logic [WID_W-1:0] width_of(input logic [CUR_W-1:0] idx);
      logic [5:0] t;
      t = 6'(idx);
      if (int'(idx) >= FIELD_COUNT || int'(idx) >= TAB_N) begin
         return '0;
      end
      return WIDTH_TABLE[t];
   endfunction

   typedef struct packed {
      logic capture;  // latch the incoming item
      logic exec;     // decode, check, start/load, first read
      logic rd;       // read the word at the cursor
      logic piece;    // move one field piece
      logic fetch;    // take the fetched word
      logic fin;      // load the result register
   } ftbp_cmd_type;

   typedef struct packed {
      logic walk_go;
      logic fetch_go;
      logic more;
   } ftbp_sts_type;

endpackage

FILE: src/ftbp_ctrl.sv
module ftbp_ctrl import ftbp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ftbp_cmd_type cmd,
   input  ftbp_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_RD, S_PIECE, S_FETCH, S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.walk_go) begin
               state_in = S_PIECE;
            end else if (sts.fetch_go) begin
               state_in = S_FETCH;
            end else begin
               state_in = S_FIN;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_PIECE;
         end
         S_PIECE: begin
            cmd.piece = 1'b1;
            state_in  = sts.more ? S_RD : S_FIN;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.fin      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/ftbp_dpath.sv
module ftbp_dpath import ftbp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ftbp_cmd_type       cmd,
   output ftbp_sts_type       sts,
   input  logic [3:0]         req_opcode,
   input  logic [WORD_W-1:0]  req_write_value,
   input  logic [CNT_W-1:0]   req_bit_count,
   input  logic               req_clear_flag,
   input  logic [5:0]         req_field_index,
   output logic [WORD_W-1:0]  rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [POS_W-1:0]   rsp_stream_position
);

   // latched item
   logic [3:0]        op_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              clear_ff;
   logic [5:0]        idx_ff;
   logic [WORD_W-1:0] data_ff;

   // stream state
   logic [CUR_W-1:0]  cursor_ff;
   logic [4:0]        bif_ff;
   logic [POS_W-1:0]  consumed_ff;
   logic              reading_ff;
   logic              ones_ff;
   logic [FIELD_COUNT-1:0] valid_ff;

   // walk state
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  pos_ff;
   logic [WORD_W-1:0] acc_ff;
   logic [1:0]        stat_ff;

   // field word store
   logic [WORD_W-1:0] mem [FIELD_COUNT];
   logic [WORD_W-1:0] rdata_ff;
   logic              rvalid_ff;

   logic [WORD_W-1:0] rsp_value_ff;
   logic [1:0]        rsp_status_ff;
   logic [POS_W-1:0]  rsp_pos_ff;

   // decode
   logic              is_wr, is_rd, is_skip, idx_ok, cur_ok, over;
   logic [1:0]        exec_status;
   logic [CNT_W-1:0]  cnt_clamp;
   logic [WORD_W-1:0] neg_val, mag_in, data_cap;

   // piece
   logic [WID_W-1:0]  w, room, take, bif_sum;
   logic [WORD_W-1:0] old_word, mask_take, field_mask, new_bits, new_word, got;
   logic              wrap, more;
   logic [CUR_W-1:0]  cursor_nx;
   logic [CNT_W-1:0]  rem_nx;

   // memory ports
   logic              use_idx, rd_ok, we;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [WORD_W-1:0] wr_data;

   logic [WORD_W-1:0] mag_out, result;

   // ---- capture ----
   always_comb begin
      cnt_clamp = (req_bit_count > CNT_W'(WORD_W)) ? CNT_W'(WORD_W) : req_bit_count;
      neg_val   = ~req_write_value + 1'b1;
      mag_in    = req_write_value[WORD_W-1] ? neg_val : req_write_value;
      // signed write: sign bit first, then the magnitude
      data_cap  = (req_opcode == OP_WRITE_SIGNED) ?
                  {mag_in[WORD_W-2:0], req_write_value[WORD_W-1]} : req_write_value;
   end

   // ---- decode ----
   always_comb begin
      is_wr   = (op_ff == OP_WRITE) || (op_ff == OP_WRITE_SIGNED);
      is_rd   = (op_ff == OP_READ) || (op_ff == OP_READ_SIGNED);
      is_skip = (op_ff == OP_SKIP);
      idx_ok  = int'(idx_ff) < FIELD_COUNT;
      cur_ok  = int'(cursor_ff) < FIELD_COUNT;
      over    = ({1'b0, consumed_ff} + (POS_W+1)'(cnt_ff)) > (POS_W+1)'(BIT_LIMIT);
      exec_status = ST_OK;
      if (is_wr) begin
         exec_status = reading_ff ? ST_MODE : (over ? ST_LIMIT : ST_OK);
      end else if (is_rd) begin
         exec_status = !reading_ff ? ST_MODE : (over ? ST_LIMIT : ST_OK);
      end else if ((op_ff == OP_LOAD_FIELD) || (op_ff == OP_FETCH_FIELD)) begin
         exec_status = idx_ok ? ST_OK : ST_INDEX;
      end
      sts.walk_go  = (is_skip || ((is_wr || is_rd) && (exec_status == ST_OK))) &&
                     (cnt_ff != '0) && cur_ok;
      sts.fetch_go = (op_ff == OP_FETCH_FIELD) && idx_ok;
      sts.more     = more;
   end

   // ---- one field piece ----
   always_comb begin
      old_word   = rvalid_ff ? rdata_ff : '0;
      w          = width_of(cursor_ff);
      room       = (w > WID_W'(bif_ff)) ? (w - WID_W'(bif_ff)) : '0;
      take       = (WID_W'(rem_ff) < room) ? WID_W'(rem_ff) : room;
      mask_take  = (take >= WID_W'(WORD_W)) ? '1 : ((WORD_W'(1) << take[4:0]) - 1'b1);
      field_mask = mask_take << bif_ff;
      new_bits   = (data_ff & mask_take) << bif_ff;
      new_word   = ones_ff ? (old_word | new_bits) : ((old_word & ~field_mask) | new_bits);
      got        = ((old_word >> bif_ff) & mask_take) << pos_ff[4:0];
      bif_sum    = WID_W'(bif_ff) + take;
      wrap       = (bif_sum >= w);
      cursor_nx  = wrap ? (cursor_ff + 1'b1) : cursor_ff;
      rem_nx     = rem_ff - CNT_W'(take);
      more       = (rem_nx != '0) && (int'(cursor_nx) < FIELD_COUNT);
   end

   // ---- memory ports ----
   always_comb begin
      use_idx = cmd.exec && (op_ff == OP_FETCH_FIELD);
      rd_addr = use_idx ? idx_ff[ADDR_W-1:0] : cursor_ff[ADDR_W-1:0];
      rd_ok   = use_idx ? idx_ok : cur_ok;
      we      = (cmd.piece && is_wr) || (cmd.exec && (op_ff == OP_LOAD_FIELD) && idx_ok);
      wr_addr = cmd.piece ? cursor_ff[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
      wr_data = cmd.piece ? new_word : data_ff;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if ((cmd.exec || cmd.rd) && rd_ok) begin
         rdata_ff  <= mem[rd_addr];
         rvalid_ff <= valid_ff[rd_addr];
      end
   end

   // ---- stream state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff   <= '0;
         bif_ff      <= '0;
         consumed_ff <= '0;
         reading_ff  <= 1'b0;
         ones_ff     <= 1'b0;
         valid_ff    <= '0;
      end else begin
         if (cmd.exec && ((op_ff == OP_START_WRITE) || (op_ff == OP_START_READ))) begin
            cursor_ff   <= '0;
            bif_ff      <= '0;
            consumed_ff <= '0;
            reading_ff  <= (op_ff == OP_START_READ);
            if (op_ff == OP_START_WRITE) begin
               ones_ff <= clear_ff;
            end
         end
         if (cmd.piece) begin
            cursor_ff   <= cursor_nx;
            bif_ff      <= wrap ? '0 : bif_sum[4:0];
            consumed_ff <= consumed_ff + POS_W'(take);
         end
         if (cmd.exec && (op_ff == OP_START_WRITE) && clear_ff) begin
            valid_ff <= '0;
         end else if (we) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // ---- item and walk payload ----
   always_comb begin
      mag_out = acc_ff >> 1;
      result  = acc_ff;
      if (op_ff == OP_READ_SIGNED) begin
         result = acc_ff[0] ? (~mag_out + 1'b1) : mag_out;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         cnt_ff   <= cnt_clamp;
         clear_ff <= req_clear_flag;
         idx_ff   <= req_field_index;
         data_ff  <= data_cap;
      end
      if (cmd.exec) begin
         stat_ff <= exec_status;
         acc_ff  <= '0;
         rem_ff  <= cnt_ff;
         pos_ff  <= '0;
      end
      if (cmd.piece) begin
         rem_ff  <= rem_nx;
         pos_ff  <= pos_ff + CNT_W'(take);
         data_ff <= data_ff >> take;
         if (is_rd) begin
            acc_ff <= acc_ff | got;
         end
      end
      if (cmd.fetch) begin
         acc_ff <= old_word;
      end
      if (cmd.fin) begin
         rsp_value_ff  <= result;
         rsp_status_ff <= stat_ff;
         rsp_pos_ff    <= consumed_ff;
      end
   end

   assign rsp_read_value      = rsp_value_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_stream_position = rsp_pos_ff;

endmodule

FILE: src/field_table_bit_packer.sv
// Field-table bit packer. Each item carries one operation on a bit stream
// laid over a fixed table of 32-bit field words (46 stream fields, 758 bits,
// plus one word reachable only by load_field/fetch_field), and yields
// exactly one result item with read_value, status and stream_position.
// Items are taken one at a time; the input stalls from acceptance until the
// controller returns to idle, while a finished result may still sit in the
// output register waiting to be taken. Each item is captured, executed and
// finished into the result register; fetch adds a step to take the
// registered read. Start, load, undefined opcodes and any rejected,
// zero-count or end-of-table operation go from execute straight to finish.
// A write, read or skip does one memory read plus one modify/write per
// field piece, since the word store has a single registered read port. A
// 32-bit access over byte-wide fields touches up to five pieces. The finish
// step waits while an earlier result is still stalled in the output
// register. Field words come out of reset as zero through per-word valid
// bits; start_write with clear set zeroes them all.
module field_table_bit_packer import ftbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [3:0]        req_opcode,
   input  logic [31:0]       req_write_value,
   input  logic [5:0]        req_bit_count,
   input  logic              req_clear_flag,
   input  logic [5:0]        req_field_index,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_read_value,
   output logic [1:0]        rsp_status,
   output logic [9:0]        rsp_stream_position
);

   ftbp_cmd_type cmd;
   ftbp_sts_type sts;

   // sequencer: one state per step of an item
   ftbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // cursor, field store, piece logic and result register
   ftbp_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_opcode          (req_opcode),
      .req_write_value     (req_write_value),
      .req_bit_count       (req_bit_count),
      .req_clear_flag      (req_clear_flag),
      .req_field_index     (req_field_index),
      .rsp_read_value      (rsp_read_value),
      .rsp_status          (rsp_status),
      .rsp_stream_position (rsp_stream_position)
   );

   // an accepted item blocks the input until it completes
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again right after an accept");

   // finishing an item always presents a result
   a_fin_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> rsp_valid)
      else $error("finished item not presented");

   // stream position never runs past the bit limit
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_stream_position) <= BIT_LIMIT))
      else $error("stream position beyond limit");

   // every error result reads zero
   a_error_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_read_value == '0))
      else $error("nonzero value on error");

endmodule
